FILE: hdl/llars_pkg.sv
package llars_pkg;

   // Board geometry.
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = 64;
   localparam int COLS_W   = 7;
   localparam int RULE_W   = 4;
   localparam int IDX_W    = $clog2(MAX_COLS);

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_MAX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SURVIVE_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SURVIVE_MAX   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_CORNERS = 3'd5;
   localparam int CSR_DATA_W = 7;

   // Reset values of the registers.
   localparam logic [COLS_W-1:0] RST_COLS_IN_USE = 7'd64;
   localparam logic [RULE_W-1:0] RST_BIRTH_MIN   = 4'd2;
   localparam logic [RULE_W-1:0] RST_BIRTH_MAX   = 4'd4;
   localparam logic [RULE_W-1:0] RST_SURVIVE_MIN = 4'd4;
   localparam logic [RULE_W-1:0] RST_SURVIVE_MAX = 4'd5;

   // Row counter codes.
   localparam logic [1:0] SEEN_NONE  = 2'd0;
   localparam logic [1:0] SEEN_TOP   = 2'd1;
   localparam logic [1:0] SEEN_BELOW = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0] row_cells;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] next_row_cells;
      logic             board_done;
   } rsp_type;

   typedef struct packed {
      logic [RULE_W-1:0] birth_min;
      logic [RULE_W-1:0] birth_max;
      logic [RULE_W-1:0] survive_min;
      logic [RULE_W-1:0] survive_max;
   } rule_type;

   typedef struct packed {
      logic [COLS_W-1:0] cols_in_use;
      rule_type          rule;
      logic              clear_corners;
   } cfg_type;

   // One row to evolve, with its neighbors and placement on the board.
   typedef struct packed {
      logic [ROW_W-1:0] up;
      logic [ROW_W-1:0] mid;
      logic [ROW_W-1:0] low;
      logic             is_top;
      logic             is_bottom;
      logic             done;
   } job_type;

   // Board width clamped to 1..MAX_COLS.
   function automatic logic [COLS_W-1:0] clamp_width(input logic [COLS_W-1:0] cols);
      logic [COLS_W-1:0] w;
      w = cols;
      if (w == '0) begin
         w = COLS_W'(1);
      end
      if (w > COLS_W'(MAX_COLS)) begin
         w = COLS_W'(MAX_COLS);
      end
      return w;
   endfunction

   // One bit per column that lies on the board.
   function automatic logic [ROW_W-1:0] width_mask(input logic [COLS_W-1:0] w);
      logic [ROW_W-1:0] m;
      for (int j = 0; j < ROW_W; j++) begin
         m[j] = (COLS_W'(j) < w);
      end
      return m;
   endfunction

endpackage

FILE: hdl/llars_lane.sv
module llars_lane
   import llars_pkg::*;
(
   input  logic [2:0] up,
   input  logic [2:0] mid,
   input  logic [2:0] low,
   input  rule_type   rule,
   output logic       next_live
);

   logic [RULE_W-1:0] count;
   logic              live;

   // Count the eight neighbors around the center cell.
   assign count = RULE_W'(up[0]) + RULE_W'(up[1]) + RULE_W'(up[2])
                + RULE_W'(mid[0]) + RULE_W'(mid[2])
                + RULE_W'(low[0]) + RULE_W'(low[1]) + RULE_W'(low[2]);

   assign live = mid[1];

   // Survival range for a live cell, birth range for a dead one.
   always_comb begin
      if (live) begin
         next_live = (count >= rule.survive_min) && (count <= rule.survive_max);
      end else begin
         next_live = (count >= rule.birth_min) && (count <= rule.birth_max);
      end
   end

endmodule

FILE: hdl/llars_window.sv
module llars_window
   import llars_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);

   logic [ROW_W-1:0] upper_ff, upper_in;
   logic [ROW_W-1:0] middle_ff, middle_in;
   logic [1:0]       seen_ff, seen_in;
   logic             pend_ff, pend_in;
   logic             job_valid_ff, job_valid_in;
   job_type          job_ff, job_in;
   logic             load;
   logic             accept;

   // The job register can take a new row when empty or draining.
   assign load      = !job_valid_ff || job_ready;
   assign req_ready = load && !pend_ff;
   assign accept    = req_valid && req_ready;

   // Row window control: first phase on the accepted beat, second phase for the
   // bottom row that follows a last_row beat.
   always_comb begin
      upper_in     = upper_ff;
      middle_in    = middle_ff;
      seen_in      = seen_ff;
      pend_in      = pend_ff;
      job_valid_in = job_valid_ff && !job_ready;
      job_in       = job_ff;
      if (pend_ff && load) begin
         job_in       = '{up: upper_ff, mid: middle_ff, low: '0,
                          is_top: 1'b0, is_bottom: 1'b1, done: 1'b1};
         job_valid_in = 1'b1;
         pend_in      = 1'b0;
         upper_in     = '0;
         middle_in    = '0;
         seen_in      = SEEN_NONE;
      end else if (accept) begin
         if (seen_ff == SEEN_NONE) begin
            if (req_payload.last_row) begin
               // Single-row board.
               job_in       = '{up: '0, mid: req_payload.row_cells, low: '0,
                                is_top: 1'b1, is_bottom: 1'b1, done: 1'b1};
               job_valid_in = 1'b1;
            end else begin
               upper_in  = '0;
               middle_in = req_payload.row_cells;
               seen_in   = SEEN_TOP;
            end
         end else begin
            job_in       = '{up: upper_ff, mid: middle_ff, low: req_payload.row_cells,
                             is_top: (seen_ff == SEEN_TOP), is_bottom: 1'b0, done: 1'b0};
            job_valid_in = 1'b1;
            upper_in     = middle_ff;
            middle_in    = req_payload.row_cells;
            if (req_payload.last_row) begin
               pend_in = 1'b1;
            end else begin
               seen_in = SEEN_BELOW;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         middle_ff    <= '0;
         seen_ff      <= SEEN_NONE;
         pend_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         upper_ff     <= upper_in;
         middle_ff    <= middle_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         job_valid_ff <= job_valid_in;
      end
   end

   // Job payload.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

FILE: hdl/llars_merge.sv
module llars_merge
   import llars_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  job_type          job,
   input  logic [ROW_W-1:0] lane_live,
   input  cfg_type          cfg,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [COLS_W-1:0] width;
   logic [IDX_W-1:0] last_col;
   logic [ROW_W-1:0] row;
   logic             take;

   assign width    = clamp_width(cfg.cols_in_use);
   assign last_col = IDX_W'(width - COLS_W'(1));

   // Gather the lanes, trim to the board and clear the corners.
   always_comb begin
      row = lane_live & width_mask(width);
      if (cfg.clear_corners && job.is_top) begin
         row[0] = 1'b0;
      end
      if (cfg.clear_corners && job.is_bottom) begin
         row[last_col] = 1'b0;
      end
   end

   // Output register.
   assign job_ready = !rsp_valid_ff || rsp_ready;
   assign take      = job_valid && job_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{next_row_cells: row, board_done: job.done};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/life_like_automaton_row_step.sv
// One generation of a life-like cellular automaton, one board row per beat.
// Rows enter on the req_ channel top to bottom; req_payload.last_row marks the
// bottom row. Results leave on the rsp_ channel in row order, each result
// row trailing its input by one row: the first input row gives no beat, each
// later row gives one, and the bottom row gives two, the second carrying
// board_done (a single-row board gives one beat). The csr_ channel writes the
// board width, the birth and survival ranges and the corner-clear flag;
// csr_ready is always high.
// A result passes the row window register and 64 neighbor-count lanes into
// the output register. Throughput is one row per cycle while rsp_ready holds;
// a last_row beat after the first holds req_ready low while the bottom row is
// issued. When the receiver stalls, the output register holds its beat, the
// window register fills behind it and req_ready drops until rsp_ready returns.
// Reset clears the row window and all valids and loads the register
// defaults: width 64, birth 2..4, survival 4..5, corners cleared.
module life_like_automaton_row_step
   import llars_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type          cfg_ff, cfg_in;
   logic             job_valid;
   logic             job_ready;
   job_type          job;
   logic [ROW_W-1:0] mask;
   logic [ROW_W+1:0] up_pad;
   logic [ROW_W+1:0] mid_pad;
   logic [ROW_W+1:0] low_pad;
   logic [ROW_W-1:0] lane_live;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS_IN_USE:   cfg_in.cols_in_use      = csr_data[COLS_W-1:0];
            CSR_BIRTH_MIN:     cfg_in.rule.birth_min   = csr_data[RULE_W-1:0];
            CSR_BIRTH_MAX:     cfg_in.rule.birth_max   = csr_data[RULE_W-1:0];
            CSR_SURVIVE_MIN:   cfg_in.rule.survive_min = csr_data[RULE_W-1:0];
            CSR_SURVIVE_MAX:   cfg_in.rule.survive_max = csr_data[RULE_W-1:0];
            CSR_CLEAR_CORNERS: cfg_in.clear_corners    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cols_in_use: RST_COLS_IN_USE,
                     rule: '{birth_min: RST_BIRTH_MIN, birth_max: RST_BIRTH_MAX,
                             survive_min: RST_SURVIVE_MIN,
                             survive_max: RST_SURVIVE_MAX},
                     clear_corners: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Row window and job register.
   llars_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job)
   );

   // Off-board columns read as dead; pad one dead column on each side.
   assign mask    = width_mask(clamp_width(cfg_ff.cols_in_use));
   assign up_pad  = {1'b0, job.up  & mask, 1'b0};
   assign mid_pad = {1'b0, job.mid & mask, 1'b0};
   assign low_pad = {1'b0, job.low & mask, 1'b0};

   // One lane per column.
   for (genvar j = 0; j < ROW_W; j++) begin : g_lane
      llars_lane u_lane (
         .up        (up_pad[j+2:j]),
         .mid       (mid_pad[j+2:j]),
         .low       (low_pad[j+2:j]),
         .rule      (cfg_ff.rule),
         .next_live (lane_live[j])
      );
   end

   // Merge the lanes into the output register.
   llars_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job),
      .lane_live   (lane_live),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/life_like_automaton_row_step_tb.sv
`timescale 1ns / 100ps

module life_like_automaton_row_step_tb;
   import llars_pkg::*;

   localparam real CLK_PERIOD     = 12.0;
   localparam int  RESET_CYCLES   = 9;
   localparam int  SETTLE_CYCLES  = 8;
   localparam int  WATCHDOG_LIMIT = 1000;
   localparam int  PHASES         = 16;
   localparam int  ROWS_PER_PHASE = 112;
   localparam int  REPORT_LIMIT   = 10;

   // Register indexes that decode to nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   // Next-generation predictor with its own copy of the registers and row window.
   class generation_scoreboard;
      logic [COLS_W-1:0] cols_in_use;
      logic [RULE_W-1:0] birth_min;
      logic [RULE_W-1:0] birth_max;
      logic [RULE_W-1:0] survive_min;
      logic [RULE_W-1:0] survive_max;
      logic              clear_corners;
      logic [ROW_W-1:0]  upper_row;
      logic [ROW_W-1:0]  middle_row;
      logic [1:0]        rows_seen;
      rsp_type           expected_rows[$];
      int unsigned       mismatches;

      function new();
         cols_in_use   = RST_COLS_IN_USE;
         birth_min     = RST_BIRTH_MIN;
         birth_max     = RST_BIRTH_MAX;
         survive_min   = RST_SURVIVE_MIN;
         survive_max   = RST_SURVIVE_MAX;
         clear_corners = 1'b1;
         upper_row     = '0;
         middle_row    = '0;
         rows_seen     = SEEN_NONE;
         mismatches    = 0;
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_COLS_IN_USE:   cols_in_use   = data[COLS_W-1:0];
            CSR_BIRTH_MIN:     birth_min     = data[RULE_W-1:0];
            CSR_BIRTH_MAX:     birth_max     = data[RULE_W-1:0];
            CSR_SURVIVE_MIN:   survive_min   = data[RULE_W-1:0];
            CSR_SURVIVE_MAX:   survive_max   = data[RULE_W-1:0];
            CSR_CLEAR_CORNERS: clear_corners = data[0];
            default: ;
         endcase
      endfunction

      // One row of the next generation from the row and its two neighbors.
      function logic [ROW_W-1:0] next_generation(input logic [ROW_W-1:0] up,
                                                 input logic [ROW_W-1:0] mid,
                                                 input logic [ROW_W-1:0] low,
                                                 input bit is_top,
                                                 input bit is_bottom);
         int               w;
         int               cnt;
         logic [ROW_W-1:0] m;
         logic [ROW_W-1:0] res;
         w = int'(cols_in_use);
         if (w < 1) w = 1;
         if (w > MAX_COLS) w = MAX_COLS;
         m = (w >= ROW_W) ? '1 : ((ROW_W'(1) << w) - ROW_W'(1));
         up  = up & m;
         mid = mid & m;
         low = low & m;
         res = '0;
         for (int j = 0; j < w; j++) begin
            cnt = 0;
            for (int d = -1; d <= 1; d++) begin
               if (j + d >= 0 && j + d < w) begin
                  cnt += up[j+d] + low[j+d];
                  if (d != 0) cnt += mid[j+d];
               end
            end
            if (mid[j]) begin
               res[j] = (cnt >= int'(survive_min)) && (cnt <= int'(survive_max));
            end else begin
               res[j] = (cnt >= int'(birth_min)) && (cnt <= int'(birth_max));
            end
         end
         if (clear_corners) begin
            if (is_top) res[0] = 1'b0;
            if (is_bottom) res[w-1] = 1'b0;
         end
         return res & m;
      endfunction

      // A row after the first completes the held row; a bottom row after the first completes two.
      function void note_row(input req_type item);
         rsp_type result;
         if (rows_seen == SEEN_NONE) begin
            if (item.last_row) begin
               result.next_row_cells = next_generation('0, item.row_cells, '0, 1'b1, 1'b1);
               result.board_done = 1'b1;
               expected_rows = {expected_rows, result};
            end else begin
               upper_row  = '0;
               middle_row = item.row_cells;
               rows_seen  = SEEN_TOP;
            end
         end else begin
            result.next_row_cells = next_generation(upper_row, middle_row, item.row_cells,
                                                    rows_seen == SEEN_TOP, 1'b0);
            result.board_done = 1'b0;
            expected_rows = {expected_rows, result};
            if (item.last_row) begin
               result.next_row_cells = next_generation(middle_row, item.row_cells, '0,
                                                       1'b0, 1'b1);
               result.board_done = 1'b1;
               expected_rows = {expected_rows, result};
               upper_row  = '0;
               middle_row = '0;
               rows_seen  = SEEN_NONE;
            end else begin
               upper_row  = middle_row;
               middle_row = item.row_cells;
               rows_seen  = SEEN_BELOW;
            end
         end
      endfunction

      // Compare a result beat with the oldest expected row.
      function void check_row(input rsp_type got);
         rsp_type want;
         if (expected_rows.size() == 0) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("unexpected result beat: cells %h done %b",
                        got.next_row_cells, got.board_done);
            end
            mismatches++;
         end else begin
            want = expected_rows.pop_front();
            if (got.next_row_cells !== want.next_row_cells ||
                got.board_done !== want.board_done) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("result mismatch: expected cells %h done %b, got cells %h done %b",
                           want.next_row_cells, want.board_done,
                           got.next_row_cells, got.board_done);
               end
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int                    send_idle_pct = 0;
   int                    stall_pct     = 0;
   int                    idle_cycles   = 0;
   generation_scoreboard  board_check   = new();

   life_like_automaton_row_step uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Observe every beat on all three channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board_check.write_register(csr_index, csr_data);
         if (req_valid && req_ready) board_check.note_row(req_payload);
         if (rsp_valid && rsp_ready) board_check.check_row(rsp_payload);
      end
   end

   // Watchdog on cycles without any beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[life_like_automaton_row_step] ERROR");
         $finish;
      end
   end

   // Offer one row, with a random gap ahead of it.
   task automatic send_row(input logic [ROW_W-1:0] cells, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_payload.row_cells   <= cells;
      req_payload.last_row    <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write all registers; unused upper data bits carry noise.
   task automatic load_rules(input int cols, input int bmin, input int bmax,
                             input int smin, input int smax, input bit corners);
      csr_write(CSR_COLS_IN_USE, CSR_DATA_W'(cols));
      csr_write(CSR_BIRTH_MIN, {(CSR_DATA_W-RULE_W)'($urandom), RULE_W'(bmin)});
      csr_write(CSR_BIRTH_MAX, {(CSR_DATA_W-RULE_W)'($urandom), RULE_W'(bmax)});
      csr_write(CSR_SURVIVE_MIN, {(CSR_DATA_W-RULE_W)'($urandom), RULE_W'(smin)});
      csr_write(CSR_SURVIVE_MAX, {(CSR_DATA_W-RULE_W)'($urandom), RULE_W'(smax)});
      csr_write(CSR_CLEAR_CORNERS, {(CSR_DATA_W-1)'($urandom), corners});
      if ($urandom_range(3) == 0) begin
         csr_write($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, CSR_DATA_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Wait until every expected row has arrived and the pipeline is empty.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (board_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ROW_W-1:0] random_row();
      logic [ROW_W-1:0] a;
      logic [ROW_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return a & b & {$urandom, $urandom};
         3, 4: return a & b;
         5, 6: return a | b;
         default: return a;
      endcase
   endfunction

   function automatic int rule_bound();
      return ($urandom_range(7) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
   endfunction

   // Random board width and rules, with the width extremes weighted up.
   task automatic random_setting();
      int cols;
      case ($urandom_range(7))
         0: cols = $urandom_range(3);
         1: cols = $urandom_range(127, 65);
         2: cols = MAX_COLS;
         default: cols = $urandom_range(MAX_COLS, 1);
      endcase
      if ($urandom_range(3) == 0) begin
         load_rules(cols, 3, 3, 2, 3, 1'($urandom_range(1)));
      end else begin
         load_rules(cols, rule_bound(), rule_bound(), rule_bound(), rule_bound(),
                    1'($urandom_range(1)));
      end
   endtask

   task automatic send_board(input int height, input bit closed);
      for (int r = 0; r < height; r++) begin
         send_row(random_row(), closed && (r == height - 1));
      end
   endtask

   initial begin
      int sent;
      int height;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_COLS_IN_USE;
      csr_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed boards under the reset rules: a single-row board and small boards.
      send_row('1, 1'b1);
      send_row('1, 1'b0);
      send_row('0, 1'b0);
      send_row('1, 1'b1);
      send_row({32{2'b01}}, 1'b0);
      send_row({32{2'b10}}, 1'b1);
      wait_until_idle();

      // One column wide, every count in both ranges, corners kept.
      load_rules(1, 0, 8, 0, 8, 1'b0);
      send_row('1, 1'b1);
      send_row('0, 1'b1);
      send_row('1, 1'b0);
      send_row(random_row(), 1'b0);
      send_row('1, 1'b1);
      wait_until_idle();

      // Width zero reads as one column; empty birth range.
      load_rules(0, 15, 9, 8, 8, 1'b1);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      wait_until_idle();

      // Width beyond the maximum; only a full neighborhood gives birth.
      load_rules(127, 8, 8, 0, 0, 1'b1);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      wait_until_idle();

      // Rules changed while a board is half way through.
      load_rules(3, 3, 3, 2, 3, 1'b1);
      send_row('1, 1'b0);
      send_row(random_row(), 1'b0);
      wait_until_idle();
      load_rules(64, 1, 3, 2, 6, 1'b1);
      send_row(random_row(), 1'b1);
      wait_until_idle();

      // Random boards, rotating through the idling styles.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_idle();
         random_setting();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         sent = 0;
         while (sent < ROWS_PER_PHASE) begin
            height = ($urandom_range(7) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
            if (height > ROWS_PER_PHASE - sent) height = ROWS_PER_PHASE - sent;
            send_board(height, (sent + height < ROWS_PER_PHASE) || ($urandom_range(2) != 0));
            sent += height;
         end
      end

      wait_until_idle();
      if (board_check.mismatches == 0 && board_check.pending() == 0) begin
         $display("[life_like_automaton_row_step] OK");
      end else begin
         $display("[life_like_automaton_row_step] ERROR");
      end
      $finish;
   end

endmodule
